// ===== hdl/schr_pkg.sv =====
// Shared types and constants for the stereo cubic Hermite resampler.
// Used by schr_cubic and stereo_cubic_hermite_resampler_unit; no dependencies.
`timescale 1ns / 1ps

package schr_pkg;

    // Default geometry
    localparam int FRAMES_DEF        = 1024;
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 16;

    // Fixed field widths
    localparam int MODE_W     = 2;
    localparam int INDEX_W    = 10;
    localparam int POS_W      = 26;
    localparam int RATIO_W    = 18;
    localparam int HELD_W     = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 18;

    // Item modes; code 3 means nothing and is dropped
    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD = 2'd0,
        MODE_SET  = 2'd1,
        MODE_EMIT = 2'd2
    } mode_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_HELD = 1'd1;

    // Step strobes from the sequencer to each channel's cubic unit
    typedef struct packed {
        logic coef;   // capture taps, form A/B/C
        logic step1;  // t1 = R(A*f + B*F)
        logic step2;  // t2 = R(t1*f + C*F)
        logic step3;  // d  = R'(t2*f)
    } cubic_ctl_t;

endpackage

// ===== hdl/schr_cubic.sv =====
// One channel of the Catmull-Rom cubic: coefficients, three multiply steps, saturation.
// Depends on schr_pkg (cubic_ctl_t); stepped by the top-level sequencer.
`timescale 1ns / 1ps

module schr_cubic #(
    parameter int SAMPLE_BITS   = schr_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = schr_pkg::FRACTION_BITS_DEF
) (
    input  logic                          aclk,
    input  schr_pkg::cubic_ctl_t          ctl,
    input  logic signed [SAMPLE_BITS-1:0] y0,
    input  logic signed [SAMPLE_BITS-1:0] y1,
    input  logic signed [SAMPLE_BITS-1:0] y2,
    input  logic signed [SAMPLE_BITS-1:0] y3,
    input  logic        [FRACTION_BITS:0] frac,
    output logic signed [SAMPLE_BITS-1:0] result
);

    // Coefficient, intermediate and product widths
    localparam int KW = SAMPLE_BITS + 4;
    localparam int TW = SAMPLE_BITS + 5;
    localparam int PW = SAMPLE_BITS + FRACTION_BITS + 7;
    localparam logic signed [PW-1:0] HALF_F  = PW'(1) <<< (FRACTION_BITS - 1);
    localparam logic signed [PW-1:0] HALF_F1 = PW'(1) <<< FRACTION_BITS;

    logic signed [KW-1:0] ye0, ye1, ye2, ye3;
    logic signed [KW-1:0] a_next, b_next, c_next;
    logic signed [KW-1:0] a_reg, b_reg, c_reg;
    logic signed [SAMPLE_BITS-1:0] y1_reg;
    logic signed [PW-1:0] fe;
    logic signed [PW-1:0] sum1, sum2, sum3;
    logic signed [TW-1:0] t1_next, t2_next, d_next;
    logic signed [TW-1:0] t1_reg, t2_reg, d_reg;
    logic signed [TW-1:0] v;

    // Twice the Catmull-Rom coefficients
    always_comb begin
        ye0 = KW'(y0);
        ye1 = KW'(y1);
        ye2 = KW'(y2);
        ye3 = KW'(y3);
        a_next = ye3 - ye0 + (ye1 <<< 1) + ye1 - (ye2 <<< 1) - ye2;
        b_next = (ye0 <<< 1) - (ye1 <<< 2) - ye1 + (ye2 <<< 2) - ye3;
        c_next = ye2 - ye0;
    end

    // Horner steps, each rounding half up
    always_comb begin
        fe      = PW'($signed({1'b0, frac}));
        sum1    = PW'(a_reg) * fe + (PW'(b_reg) <<< FRACTION_BITS) + HALF_F;
        t1_next = TW'(sum1 >>> FRACTION_BITS);
        sum2    = PW'(t1_reg) * fe + (PW'(c_reg) <<< FRACTION_BITS) + HALF_F;
        t2_next = TW'(sum2 >>> FRACTION_BITS);
        sum3    = PW'(t2_reg) * fe + HALF_F1;
        d_next  = TW'(sum3 >>> (FRACTION_BITS + 1));
    end

    always_ff @(posedge aclk) begin
        if (ctl.coef) begin
            a_reg  <= a_next;
            b_reg  <= b_next;
            c_reg  <= c_next;
            y1_reg <= y1;
        end
        if (ctl.step1) begin
            t1_reg <= t1_next;
        end
        if (ctl.step2) begin
            t2_reg <= t2_next;
        end
        if (ctl.step3) begin
            d_reg <= d_next;
        end
    end

    // Add the base tap and clamp to the sample range
    always_comb begin
        v = TW'(y1_reg) + d_reg;
        if (v[TW-1:SAMPLE_BITS-1] == {(TW - SAMPLE_BITS + 1){v[TW-1]}}) begin
            result = v[SAMPLE_BITS-1:0];
        end else if (v[TW-1]) begin
            result = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
        end else begin
            result = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
        end
    end

endmodule

// ===== hdl/stereo_cubic_hermite_resampler_unit.sv =====
// Load and set items give no result; the next transfer may follow at once.
// Emit: the input transfer is followed by four reads on the single store read port, a
// coefficient step, three dependent multiply steps and an output load; no new item is taken
// until that load, which waits while an earlier result is still not taken. Emit with fewer than
// four frames held goes straight to the output load. Synchronous active-low reset clears the
// sequencer, output valid, ratio (1.0), frames held and read position; the store is not cleared.
`timescale 1ns / 1ps

module stereo_cubic_hermite_resampler_unit #(
    parameter int FRAMES        = schr_pkg::FRAMES_DEF,
    parameter int SAMPLE_BITS   = schr_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = schr_pkg::FRACTION_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [schr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [schr_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [schr_pkg::MODE_W-1:0]          s_mode,
    input  logic [schr_pkg::INDEX_W-1:0]         s_frame_index,
    input  logic signed [SAMPLE_BITS-1:0]        s_left_in,
    input  logic signed [SAMPLE_BITS-1:0]        s_right_in,
    input  logic [schr_pkg::POS_W-1:0]           s_position_in,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [SAMPLE_BITS-1:0]        m_left_out,
    output logic signed [SAMPLE_BITS-1:0]        m_right_out,
    output logic [schr_pkg::POS_W-1:0]           m_position_out,
    output logic                                 m_status
);

    localparam int AW     = $clog2(FRAMES);
    localparam int SW     = 2 * SAMPLE_BITS;
    localparam int POS_W  = schr_pkg::POS_W;
    localparam int HELD_W = schr_pkg::HELD_W;
    localparam logic [1:0] CNT_LAST = 2'd3;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_READ = 7'b0000010,
        ST_COEF = 7'b0000100,
        ST_MUL1 = 7'b0001000,
        ST_MUL2 = 7'b0010000,
        ST_MUL3 = 7'b0100000,
        ST_FIN  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;

    logic [schr_pkg::RATIO_W-1:0] ratio_reg;
    logic [HELD_W-1:0]            held_reg;
    logic [POS_W-1:0]             read_position_reg;

    logic [AW-1:0]            base_reg;
    logic [FRACTION_BITS:0]   f_reg;
    logic                     short_reg;
    logic [POS_W-1:0]         pos_out_reg;

    logic [SW-1:0] sample_store_mem [FRAMES];
    logic [SW-1:0] rd_data_reg;
    logic [SW-1:0] y0_reg, y1_reg, y2_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;

    logic s_fire;
    logic emit_fire;
    logic fin_load;

    logic [HELD_W-1:0]      held_c;
    logic                   short_emit;
    logic [31:0]            i_w;
    logic [FRACTION_BITS:0] f_w;
    logic [POS_W:0]         np_sum;
    logic [POS_W-1:0]       np_sat;

    schr_pkg::cubic_ctl_t ctl;
    logic signed [SAMPLE_BITS-1:0] left_res, right_res;

    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] m_left_reg, m_right_reg;
    logic [POS_W-1:0]              m_pos_reg;
    logic                          m_status_reg;

    // Handshake
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign emit_fire = s_fire && (s_mode == schr_pkg::MODE_EMIT);
    assign fin_load  = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg <= schr_pkg::RATIO_W'(1) << FRACTION_BITS;
            held_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                schr_pkg::CFG_RATIO:       ratio_reg <= cfg_data[schr_pkg::RATIO_W-1:0];
                schr_pkg::CFG_FRAMES_HELD: held_reg  <= cfg_data[HELD_W-1:0];
                default: ;
            endcase
        end
    end

    // Tap window: clamp index and fraction at both ends of the held frames
    always_comb begin
        held_c     = (int'(held_reg) > FRAMES) ? HELD_W'(FRAMES) : held_reg;
        short_emit = (held_c < HELD_W'(4));
        i_w        = 32'(read_position_reg[POS_W-1:FRACTION_BITS]);
        f_w        = {1'b0, read_position_reg[FRACTION_BITS-1:0]};
        if (i_w == 32'd0) begin
            i_w = 32'd1;
            f_w = '0;
        end
        if (i_w + 32'd2 >= 32'(held_c)) begin
            i_w = 32'(held_c) - 32'd3;
            f_w = {1'b1, {FRACTION_BITS{1'b0}}};
        end
        np_sum = {1'b0, read_position_reg} + (POS_W + 1)'(ratio_reg);
        np_sat = np_sum[POS_W] ? {POS_W{1'b1}} : np_sum[POS_W-1:0];
    end

    // Position and per-emit context
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_position_reg <= '0;
        end else if (s_fire && s_mode == schr_pkg::MODE_SET) begin
            read_position_reg <= s_position_in;
        end else if (emit_fire && !short_emit) begin
            read_position_reg <= np_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            base_reg    <= AW'(i_w - 32'd1);
            f_reg       <= f_w;
            short_reg   <= short_emit;
            pos_out_reg <= short_emit ? read_position_reg : np_sat;
        end
    end

    // Frame store: one write port for loads, one registered read port for taps
    assign wr_en   = s_fire && (s_mode == schr_pkg::MODE_LOAD)
                     && (int'(s_frame_index) < FRAMES);
    assign wr_addr = AW'(s_frame_index);
    assign rd_addr = base_reg + AW'(cnt_reg);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            sample_store_mem[wr_addr] <= {s_left_in, s_right_in};
        end
        rd_data_reg <= sample_store_mem[rd_addr];
    end

    // Tap shift line; the fourth tap is used straight from the read register
    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ && cnt_reg != 2'd0) begin
            y0_reg <= y1_reg;
            y1_reg <= y2_reg;
            y2_reg <= rd_data_reg;
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = '0;
        case (state_reg)
            ST_IDLE: begin
                if (emit_fire) begin
                    state_next = short_emit ? ST_FIN : ST_READ;
                end
            end
            ST_READ: begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_COEF;
                end
            end
            ST_COEF: state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_MUL3;
            ST_MUL3: state_next = ST_FIN;
            ST_FIN: begin
                if (fin_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Channel datapaths
    assign ctl.coef  = (state_reg == ST_COEF);
    assign ctl.step1 = (state_reg == ST_MUL1);
    assign ctl.step2 = (state_reg == ST_MUL2);
    assign ctl.step3 = (state_reg == ST_MUL3);

    schr_cubic #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_cubic_left (
        .aclk   (aclk),
        .ctl    (ctl),
        .y0     ($signed(y0_reg[SW-1:SAMPLE_BITS])),
        .y1     ($signed(y1_reg[SW-1:SAMPLE_BITS])),
        .y2     ($signed(y2_reg[SW-1:SAMPLE_BITS])),
        .y3     ($signed(rd_data_reg[SW-1:SAMPLE_BITS])),
        .frac   (f_reg),
        .result (left_res)
    );

    schr_cubic #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_cubic_right (
        .aclk   (aclk),
        .ctl    (ctl),
        .y0     ($signed(y0_reg[SAMPLE_BITS-1:0])),
        .y1     ($signed(y1_reg[SAMPLE_BITS-1:0])),
        .y2     ($signed(y2_reg[SAMPLE_BITS-1:0])),
        .y3     ($signed(rd_data_reg[SAMPLE_BITS-1:0])),
        .frac   (f_reg),
        .result (right_res)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fin_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_load) begin
            m_left_reg   <= short_reg ? '0 : left_res;
            m_right_reg  <= short_reg ? '0 : right_res;
            m_pos_reg    <= pos_out_reg;
            m_status_reg <= short_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_left_out     = m_left_reg;
    assign m_right_out    = m_right_reg;
    assign m_position_out = m_pos_reg;
    assign m_status       = m_status_reg;

`ifndef SYNTHESIS
    // A full emit starts the tap reads on the next cycle
    a_emit_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fire && !short_emit |=> state_reg == ST_READ)
        else $error("emit transfer did not start store reads");

    // Coefficients are formed only after the fourth tap read
    a_coef_after_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_COEF |-> $past(state_reg == ST_READ && cnt_reg == CNT_LAST))
        else $error("coefficient step without four tap reads");

    // A new result appears only out of the final state
    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside the final state");

    // Too-few-frames results carry silent samples
    a_short_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg |-> m_left_reg == '0 && m_right_reg == '0)
        else $error("status result with nonzero samples");
`endif

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for stereo_cubic_hermite_resampler_unit: frame loads, position
// sets and interpolated emits under random flow control, checked against a local predictor.
// Depends on schr_pkg and the resampler RTL only.
`timescale 1ns / 1ps

module tb;

    localparam int  SW             = schr_pkg::SAMPLE_BITS_DEF;
    localparam int  FB             = schr_pkg::FRACTION_BITS_DEF;
    localparam int  STORE_DEPTH    = schr_pkg::FRAMES_DEF;
    localparam int  MODE_W         = schr_pkg::MODE_W;
    localparam int  INDEX_W        = schr_pkg::INDEX_W;
    localparam int  POS_W          = schr_pkg::POS_W;
    localparam int  RATIO_W        = schr_pkg::RATIO_W;
    localparam int  HELD_W         = schr_pkg::HELD_W;
    localparam int  CFG_IDX_W      = schr_pkg::CFG_IDX_W;
    localparam int  CFG_DATA_W     = schr_pkg::CFG_DATA_W;
    localparam longint ONE         = longint'(1) << FB;
    localparam longint SAMPLE_MAX  = (longint'(1) << (SW - 1)) - 1;
    localparam longint SAMPLE_MIN  = -SAMPLE_MAX - 1;
    localparam longint POS_MAX     = (longint'(1) << POS_W) - 1;
    localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
    localparam int  ITEM_TARGET    = 1150;
    localparam int  SETTLE_CYCLES  = 16;
    localparam int  HOLDOFF_CYCLES = 400;
    localparam int  IDLE_PCT       = 7;

    // one input transfer
    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [INDEX_W-1:0]   idx;
        logic signed [SW-1:0] l;
        logic signed [SW-1:0] r;
        logic [POS_W-1:0]     pos;
    } stim_t;

    // one emitted output frame
    typedef struct packed {
        logic signed [SW-1:0] l;
        logic signed [SW-1:0] r;
        logic [POS_W-1:0]     pos;
        logic                 status;
    } frame_result_t;

    // directed script row: register write, or item with optional hand-typed result
    typedef struct packed {
        logic                  reg_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        stim_t                 item;
        logic                  typed;
        frame_result_t         want;
    } script_row_t;

    logic                  aclk;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [MODE_W-1:0]     s_mode        = '0;
    logic [INDEX_W-1:0]    s_frame_index = '0;
    logic signed [SW-1:0]  s_left_in     = '0;
    logic signed [SW-1:0]  s_right_in    = '0;
    logic [POS_W-1:0]      s_position_in = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic signed [SW-1:0]  m_left_out;
    logic signed [SW-1:0]  m_right_out;
    logic [POS_W-1:0]      m_position_out;
    logic                  m_status;

    stereo_cubic_hermite_resampler_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_frame_index  (s_frame_index),
        .s_left_in      (s_left_in),
        .s_right_in     (s_right_in),
        .s_position_in  (s_position_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_left_out     (m_left_out),
        .m_right_out    (m_right_out),
        .m_position_out (m_position_out),
        .m_status       (m_status)
    );

    // predictor state
    logic signed [SW-1:0] store_left  [STORE_DEPTH];
    logic signed [SW-1:0] store_right [STORE_DEPTH];
    bit                   loaded      [STORE_DEPTH];
    logic [POS_W-1:0]     pos_q   = '0;
    logic [RATIO_W-1:0]   ratio_q = RATIO_W'(1) << FB;
    logic [HELD_W-1:0]    held_q  = '0;

    frame_result_t pending_frames[$];
    int  failures       = 0;
    int  items_sent     = 0;
    int  holdoffs_asked = 0;
    int  holdoffs_done  = 0;
    bit  no_idle        = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    // round to nearest, halves toward +inf
    function automatic longint round_shift(longint x, int s);
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // Catmull-Rom over four taps, coefficients doubled, result saturated
    function automatic logic signed [SW-1:0] hermite(longint y0, longint y1, longint y2,
                                                     longint y3, longint frac);
        longint a, b, c, t, v;
        a = -y0 + 3 * y1 - 3 * y2 + y3;
        b = 2 * y0 - 5 * y1 + 4 * y2 - y3;
        c = y2 - y0;
        t = round_shift(a * frac + b * ONE, FB);
        t = round_shift(t * frac + c * ONE, FB);
        v = y1 + round_shift(t * frac, FB + 1);
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        if (v < SAMPLE_MIN) v = SAMPLE_MIN;
        return v[SW-1:0];
    endfunction

    function automatic int held_now();
        return (held_q > STORE_DEPTH) ? STORE_DEPTH : int'(held_q);
    endfunction

    // integer tap position after clamping at both ends of the held frames
    function automatic int tap_center(output longint frac);
        int centre;
        int held_eff;
        held_eff = held_now();
        centre   = int'(pos_q >> FB);
        frac     = longint'(pos_q[FB-1:0]);
        if (centre < 1) begin
            centre = 1;
            frac   = 0;
        end
        if (centre + 2 >= held_eff) begin
            centre = held_eff - 3;
            frac   = ONE;
        end
        return centre;
    endfunction

    // apply one accepted item; returns 1 when it produces an output frame
    function automatic bit model_step(input stim_t it, output frame_result_t res);
        int     centre;
        longint frac;
        longint next_pos;
        res = '0;
        case (it.mode)
            schr_pkg::MODE_LOAD: begin
                store_left[it.idx]  = it.l;
                store_right[it.idx] = it.r;
                loaded[it.idx]      = 1'b1;
                return 1'b0;
            end
            schr_pkg::MODE_SET: begin
                pos_q = it.pos;
                return 1'b0;
            end
            schr_pkg::MODE_EMIT: begin
                if (held_now() < 4) begin
                    res.pos    = pos_q;
                    res.status = 1'b1;
                    return 1'b1;
                end
                centre = tap_center(frac);
                res.l = hermite(store_left[centre-1], store_left[centre],
                                store_left[centre+1], store_left[centre+2], frac);
                res.r = hermite(store_right[centre-1], store_right[centre],
                                store_right[centre+1], store_right[centre+2], frac);
                next_pos = longint'(pos_q) + longint'(ratio_q);
                if (next_pos > POS_MAX) next_pos = POS_MAX;
                pos_q      = next_pos[POS_W-1:0];
                res.pos    = pos_q;
                res.status = 1'b0;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic stim_t make_item(logic [MODE_W-1:0] mode, logic [INDEX_W-1:0] idx,
                                        logic signed [SW-1:0] l, logic signed [SW-1:0] r,
                                        logic [POS_W-1:0] pos);
        stim_t it;
        it.mode = mode;
        it.idx  = idx;
        it.l    = l;
        it.r    = r;
        it.pos  = pos;
        return it;
    endfunction

    function automatic script_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] val);
        script_row_t row;
        row           = '0;
        row.reg_write = 1'b1;
        row.reg_idx   = idx;
        row.reg_val   = val;
        return row;
    endfunction

    function automatic script_row_t item_row(logic [MODE_W-1:0] mode,
                                             logic [INDEX_W-1:0] idx,
                                             logic signed [SW-1:0] l,
                                             logic signed [SW-1:0] r,
                                             logic [POS_W-1:0] pos);
        script_row_t row;
        row      = '0;
        row.item = make_item(mode, idx, l, r, pos);
        return row;
    endfunction

    // emit whose result is known by inspection
    function automatic script_row_t known_row(logic signed [SW-1:0] l, logic signed [SW-1:0] r,
                                              logic [POS_W-1:0] pos, logic status);
        script_row_t row;
        row             = item_row(schr_pkg::MODE_EMIT, '0, '0, '0, '0);
        row.typed       = 1'b1;
        row.want.l      = l;
        row.want.r      = r;
        row.want.pos    = pos;
        row.want.status = status;
        return row;
    endfunction

    // extremes a quarter of the time
    function automatic logic signed [SW-1:0] pick_sample();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MIN[SW-1:0];
            1:       return SAMPLE_MAX[SW-1:0];
            default: return w[SW-1:0];
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_ratio();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return {RATIO_W{1'b1}};
            2:       return CFG_DATA_W'(1) << FB;
            3, 4:    return w[RATIO_W-1:0];
            default: return CFG_DATA_W'($urandom_range(32'h2000, 32'h28000));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_held();
        case ($urandom_range(0, 11))
            0:       return CFG_DATA_W'($urandom_range(0, 3));
            1:       return CFG_DATA_W'(STORE_DEPTH);
            2:       return CFG_DATA_W'($urandom_range(STORE_DEPTH + 1, 2047));
            3:       return CFG_DATA_W'(4);
            default: return CFG_DATA_W'($urandom_range(5, 48));
        endcase
    endfunction

    // one input transfer, with a random gap ahead of it
    task automatic offer(input stim_t it, input bit typed, input frame_result_t known);
        frame_result_t got;
        if (!no_idle) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid       <= 1'b1;
        s_mode        <= it.mode;
        s_frame_index <= it.idx;
        s_left_in     <= it.l;
        s_right_in    <= it.r;
        s_position_in <= it.pos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (model_step(it, got)) pending_frames.push_back(typed ? known : got);
        if (it.mode != MODE_IGNORED) items_sent++;
    endtask

    // drop valid and wait until every frame has come back and the block is quiet
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == schr_pkg::CFG_RATIO) ratio_q = val[RATIO_W-1:0];
        else                            held_q  = val[HELD_W-1:0];
    endtask

    // an emit must never read a frame that was never loaded
    task automatic load_missing_taps();
        longint frac;
        int     centre;
        if (held_now() < 4) return;
        centre = tap_center(frac);
        for (int k = centre - 1; k <= centre + 2; k++) begin
            if (!loaded[k])
                offer(make_item(schr_pkg::MODE_LOAD, INDEX_W'(k), pick_sample(),
                                pick_sample(), '0), 1'b0, '0);
        end
    endtask

    // ---------------------------------------------------------------- result side

    // receiver flow control: random stalls, a quiet stretch, and requested hold-offs
    initial begin : result_flow
        forever begin
            @(posedge aclk);
            if (holdoffs_done < holdoffs_asked) begin
                m_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge aclk);
                holdoffs_done++;
            end else begin
                m_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge aclk) begin : check_results
        frame_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_frames.size() == 0) begin
                $error("unexpected frame: left_out %0d right_out %0d position_out %0h status %0d",
                       m_left_out, m_right_out, m_position_out, m_status);
                failures++;
            end else begin
                want = pending_frames.pop_front();
                if (m_left_out !== want.l) begin
                    $error("left_out: expected %0d, got %0d", want.l, m_left_out);
                    failures++;
                end
                if (m_right_out !== want.r) begin
                    $error("right_out: expected %0d, got %0d", want.r, m_right_out);
                    failures++;
                end
                if (m_position_out !== want.pos) begin
                    $error("position_out: expected %0h, got %0h", want.pos, m_position_out);
                    failures++;
                end
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    failures++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin : stimulus
        script_row_t       script[$];
        script_row_t       row;
        int                phase;
        int                n_items;
        int                pick;
        int                held_eff;
        int                top_idx;
        logic [31:0]       w;
        logic [POS_W-1:0]  pos;
        logic [INDEX_W-1:0] idx;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty store, held ends, clamps, saturating advance, ignored code
        script.push_back(known_row('0, '0, '0, 1'b1));
        script.push_back(item_row(schr_pkg::MODE_SET, '0, '0, '0, 26'h3FFFFFF));
        script.push_back(known_row('0, '0, 26'h3FFFFFF, 1'b1));
        script.push_back(reg_row(schr_pkg::CFG_FRAMES_HELD, 18'd3));
        script.push_back(known_row('0, '0, 26'h3FFFFFF, 1'b1));
        script.push_back(item_row(schr_pkg::MODE_LOAD, 10'd0, -16'sd32768, 16'sd32767, '0));
        script.push_back(item_row(schr_pkg::MODE_LOAD, 10'd1, 16'sd32767, -16'sd32768, '0));
        script.push_back(item_row(schr_pkg::MODE_LOAD, 10'd2, -16'sd1, 16'sd1, '0));
        script.push_back(item_row(schr_pkg::MODE_LOAD, 10'd3, 16'sd12345, -16'sd12345, '0));
        script.push_back(item_row(schr_pkg::MODE_LOAD, 10'd1023, 16'sd32767, -16'sd32768, '1));
        script.push_back(item_row(MODE_IGNORED, '1, -16'sd1, -16'sd1, '1));
        script.push_back(reg_row(schr_pkg::CFG_FRAMES_HELD, 18'd4));
        // far past the end: clamps to the last span, advance saturates
        script.push_back(known_row(-16'sd1, 16'sd1, 26'h3FFFFFF, 1'b0));
        script.push_back(item_row(schr_pkg::MODE_SET, '0, '0, '0, 26'h10000));
        script.push_back(known_row(16'sd32767, -16'sd32768, 26'h20000, 1'b0));
        script.push_back(known_row(-16'sd1, 16'sd1, 26'h30000, 1'b0));
        // below frame one: snaps to frame one, fraction dropped
        script.push_back(item_row(schr_pkg::MODE_SET, '0, '0, '0, 26'h0FFFF));
        script.push_back(known_row(16'sd32767, -16'sd32768, 26'h1FFFF, 1'b0));
        script.push_back(item_row(schr_pkg::MODE_SET, '0, '0, '0, 26'h18000));
        script.push_back(item_row(schr_pkg::MODE_EMIT, '0, '0, '0, '0));
        script.push_back(reg_row(schr_pkg::CFG_RATIO, 18'd0));
        script.push_back(item_row(schr_pkg::MODE_SET, '0, '0, '0, 26'h1ABCD));
        script.push_back(item_row(schr_pkg::MODE_EMIT, '0, '0, '0, '0));
        script.push_back(reg_row(schr_pkg::CFG_RATIO, 18'h3FFFF));
        script.push_back(item_row(schr_pkg::MODE_EMIT, '0, '0, '0, '0));

        foreach (script[k]) begin
            row = script[k];
            if (row.reg_write) begin
                settle();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                offer(row.item, row.typed, row.want);
            end
        end

        // random phases, each under a fresh register setting
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            settle();
            write_reg(schr_pkg::CFG_RATIO, pick_ratio());
            if (phase == 0)
                write_reg(schr_pkg::CFG_FRAMES_HELD, 18'd2047);
            else if (phase == 1)
                write_reg(schr_pkg::CFG_FRAMES_HELD, CFG_DATA_W'(STORE_DEPTH));
            else
                write_reg(schr_pkg::CFG_FRAMES_HELD, pick_held());
            no_idle = (phase == 2);
            if (phase == 3) holdoffs_asked++;
            n_items = $urandom_range(30, 70);
            repeat (n_items) begin
                pick     = $urandom_range(0, 99);
                held_eff = held_now();
                w        = $urandom();
                if (pick < 8) begin
                    // position mostly inside the held span
                    if (held_eff >= 4 && $urandom_range(0, 3) != 0)
                        pos = POS_W'($urandom_range(0, held_eff * (1 << FB) - 1));
                    else
                        pos = w[POS_W-1:0];
                    offer(make_item(schr_pkg::MODE_SET, w[31:22], pick_sample(),
                                    pick_sample(), pos), 1'b0, '0);
                end else if (pick < 22) begin
                    top_idx = (held_eff < 4) ? 5 : held_eff + 1;
                    if (top_idx > STORE_DEPTH - 1) top_idx = STORE_DEPTH - 1;
                    if ($urandom_range(0, 3) == 0) idx = w[INDEX_W-1:0];
                    else                           idx = INDEX_W'($urandom_range(0, top_idx));
                    offer(make_item(schr_pkg::MODE_LOAD, idx, pick_sample(), pick_sample(),
                                    w[31:6]), 1'b0, '0);
                end else if (pick < 25) begin
                    offer(make_item(MODE_IGNORED, w[9:0], pick_sample(), pick_sample(),
                                    w[31:6]), 1'b0, '0);
                end else begin
                    load_missing_taps();
                    offer(make_item(schr_pkg::MODE_EMIT, w[9:0], pick_sample(), pick_sample(),
                                    w[31:6]), 1'b0, '0);
                end
            end
            phase++;
        end
        no_idle = 1'b0;

        settle();
        if (failures == 0) $display("== PASS ==");
        else               $display("== FAIL ==");
        $finish;
    end

endmodule
